[sv/sjva_pkg.sv]
// Package for the sparse J^T J vector accumulation block.
// Holds the item types, action codes, lane control struct and saturation helper.
package sjva_pkg;

  localparam int LANES = 6;
  localparam int NBRS  = 4;

  typedef enum logic [1:0] {
    ACT_LOAD_X   = 2'd0,
    ACT_LOAD_ACC = 2'd1,
    ACT_APPLY    = 2'd2,
    ACT_READ_ACC = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         node_index;
    logic [2:0]         component;
    logic signed [31:0] load_value;
    logic [39:0]        neighbor_nodes;
    logic [63:0]        neighbor_weights;
    logic [47:0]        grad_rotation;
    logic [47:0]        grad_translation;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               status;
  } res_t;

  typedef struct packed {
    logic x_we;
    logic acc_we;
    logic acc_upd;
    logic prod_en;
    logic delta_en;
  } lane_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

[sv/sjva_lane.sv]
// One component lane: x and accumulator banks for one word of every node block.
// Forms the gradient-times-x product and the saturating accumulator update.
// Depends on sjva_pkg.
module sjva_lane #(
  parameter int MAX_NODES = 1024
) (
  input  logic                         clk_i,
  input  sjva_pkg::lane_ctrl_t         ctrl_i,
  input  logic [$clog2(MAX_NODES)-1:0] addr_i,
  input  logic signed [15:0]           grad_i,
  input  logic signed [31:0]           load_i,
  input  logic signed [31:0]           f_i,
  output logic signed [31:0]           acc_rd_o,
  output logic signed [47:0]           prod_o
);

  logic signed [31:0] x_mem   [MAX_NODES];
  logic signed [31:0] acc_mem [MAX_NODES];
  logic signed [31:0] x_rd_q;
  logic signed [31:0] acc_rd_q;
  logic signed [47:0] prod_q;
  logic signed [35:0] delta_q;
  logic signed [47:0] xg;
  logic signed [47:0] fg;
  logic signed [31:0] acc_new;

  assign xg      = grad_i * x_rd_q;
  assign fg      = f_i * grad_i;
  assign acc_new = sjva_pkg::sat32(66'(acc_rd_q) + 66'(delta_q));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.x_we) begin
      x_mem[addr_i] <= load_i;
    end
    if (ctrl_i.acc_we) begin
      acc_mem[addr_i] <= ctrl_i.acc_upd ? acc_new : load_i;
    end
    x_rd_q   <= x_mem[addr_i];
    acc_rd_q <= acc_mem[addr_i];
    if (ctrl_i.prod_en) begin
      prod_q <= xg;
    end
    if (ctrl_i.delta_en) begin
      delta_q <= 36'(fg >>> 12);
    end
  end

  assign acc_rd_o = acc_rd_q;
  assign prod_o   = prod_q;

endmodule

[sv/sjva_merge.sv]
// Merging stage: sums the six lane products into one scaled dot product.
// Depends on sjva_pkg.
module sjva_merge (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [47:0] prod_i [sjva_pkg::LANES],
  output logic signed [38:0] dot_o
);

  logic signed [50:0] sum;
  logic signed [38:0] dot_q;

  always_comb begin
    sum = '0;
    for (int k = 0; k < sjva_pkg::LANES; k++) begin
      sum = sum + 51'(prod_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= 39'(sum >>> 12);
    end
  end

  assign dot_o = dot_q;

endmodule

[sv/sparse_jtj_vector_accumulate.sv]
// Top level of the sparse J^T J vector accumulation block.
// Holds the sequencer and the scalar weight path; instantiates six sjva_lane and one sjva_merge.
// Depends on sjva_pkg.
//
// Usage: drive req_i and raise start; the item is taken at a clock edge where
// busy is low. Exactly one result follows per item: done_o is high for one
// cycle and res_o carries read_value and status in that cycle. The receiver
// cannot stall; the result must be taken when done_o is high.
// Load and read items pass through S_MEM to the result state S_RESP. An item
// with an index or component out of range goes straight to S_RESP and reports
// status 1. An apply item makes four passes over the neighbors for the x gather
// (read, lane multiply, merge, weight multiply), one step to scale the sum,
// then four read-modify-write passes over the accumulator banks, one
// per neighbor in order, each through one port of the component-banked
// memories, and the result state. busy stays high until done_o has been shown,
// so a new item is taken only after the previous result has been shown.
// The scale register is written over cfg_valid_i/cfg_ready_o while idle.
// Reset returns the sequencer to idle and the scale to 1.0; the memories are
// not cleared and must be loaded before use.
module sparse_jtj_vector_accumulate #(
  parameter int MAX_NODES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sjva_pkg::req_t req_i,
  output logic           done_o,
  output sjva_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i
);

  localparam int AW = $clog2(MAX_NODES);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MEM   = 13'b0000000000010,
    S_RESP  = 13'b0000000000100,
    S_XRD   = 13'b0000000001000,
    S_XPROD = 13'b0000000010000,
    S_XSUM  = 13'b0000000100000,
    S_DMUL  = 13'b0000001000000,
    S_DFIN  = 13'b0000010000000,
    S_EMUL  = 13'b0000100000000,
    S_FMUL  = 13'b0001000000000,
    S_ARD   = 13'b0010000000000,
    S_AUPD  = 13'b0100000000000,
    S_AWR   = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  sjva_pkg::req_t     item_q;
  logic               status_q, status_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [31:0]        tws_q;
  logic signed [57:0] dacc_q;
  logic signed [43:0] d_q;
  logic signed [31:0] e_q;
  logic signed [31:0] f_q;
  logic               accept;
  logic               req_bad;
  logic [9:0]         nbr_sel;
  logic [15:0]        w_sel;
  logic [AW-1:0]      addr;
  logic signed [55:0] wdot;
  logic signed [60:0] dw;
  logic signed [64:0] etws;
  logic signed [38:0] dot;
  logic signed [31:0] acc_rd [sjva_pkg::LANES];
  logic signed [47:0] prod   [sjva_pkg::LANES];
  logic signed [31:0] rd_sel;
  sjva_pkg::lane_ctrl_t ctrl [sjva_pkg::LANES];

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  always_comb begin
    req_bad = 1'b0;
    if (req_i.action == sjva_pkg::ACT_APPLY) begin
      for (int y = 0; y < sjva_pkg::NBRS; y++) begin
        if (32'(req_i.neighbor_nodes[10*y +: 10]) >= MAX_NODES) begin
          req_bad = 1'b1;
        end
      end
    end else if (32'(req_i.node_index) >= MAX_NODES || req_i.component > 3'd5) begin
      req_bad = 1'b1;
    end
  end

  assign nbr_sel = item_q.neighbor_nodes[10*cnt_q +: 10];
  assign w_sel   = item_q.neighbor_weights[16*cnt_q +: 16];
  assign addr    = (item_q.action == sjva_pkg::ACT_APPLY) ? AW'(nbr_sel) : AW'(item_q.node_index);

  assign wdot = $signed({1'b0, w_sel}) * dot;
  assign dw   = $signed({1'b0, w_sel}) * d_q;
  assign etws = e_q * $signed({1'b0, tws_q});

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = req_bad;
          cnt_d    = 2'd0;
          if (req_bad) begin
            state_d = S_RESP;
          end else if (req_i.action == sjva_pkg::ACT_APPLY) begin
            state_d = S_XRD;
          end else begin
            state_d = S_MEM;
          end
        end
      end
      S_MEM:   state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      S_XRD:   state_d = S_XPROD;
      S_XPROD: state_d = S_XSUM;
      S_XSUM:  state_d = S_DMUL;
      S_DMUL: begin
        cnt_d   = cnt_q + 2'd1;
        state_d = (cnt_q == 2'd3) ? S_DFIN : S_XRD;
      end
      S_DFIN:  state_d = S_EMUL;
      S_EMUL:  state_d = S_FMUL;
      S_FMUL:  state_d = S_ARD;
      S_ARD:   state_d = S_AUPD;
      S_AUPD:  state_d = S_AWR;
      S_AWR: begin
        cnt_d   = cnt_q + 2'd1;
        state_d = (cnt_q == 2'd3) ? S_RESP : S_EMUL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= 1'b0;
      cnt_q    <= 2'd0;
      tws_q    <= 32'd65536;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tws_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
      dacc_q <= '0;
    end
    if (state_q == S_DMUL) begin
      dacc_q <= dacc_q + 58'(wdot);
    end
    if (state_q == S_DFIN) begin
      d_q <= 44'(dacc_q >>> 14);
    end
    if (state_q == S_EMUL) begin
      e_q <= sjva_pkg::sat32(66'(dw >>> 14));
    end
    if (state_q == S_FMUL) begin
      f_q <= sjva_pkg::sat32(66'(etws >>> 16));
    end
  end

  for (genvar k = 0; k < sjva_pkg::LANES; k++) begin : g_lane
    logic signed [15:0] grad;
    logic               sel;
    assign grad = (k < 3) ? $signed(item_q.grad_rotation[16*(k%3) +: 16])
                          : $signed(item_q.grad_translation[16*(k%3) +: 16]);
    assign sel  = (item_q.component == 3'(k));
    assign ctrl[k].x_we     = (state_q == S_MEM) && sel &&
                              (item_q.action == sjva_pkg::ACT_LOAD_X);
    assign ctrl[k].acc_we   = ((state_q == S_MEM) && sel &&
                               (item_q.action == sjva_pkg::ACT_LOAD_ACC)) ||
                              (state_q == S_AWR);
    assign ctrl[k].acc_upd  = (state_q == S_AWR);
    assign ctrl[k].prod_en  = (state_q == S_XPROD);
    assign ctrl[k].delta_en = (state_q == S_AUPD);

    sjva_lane #(.MAX_NODES(MAX_NODES)) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[k]),
      .addr_i   (addr),
      .grad_i   (grad),
      .load_i   (item_q.load_value),
      .f_i      (f_q),
      .acc_rd_o (acc_rd[k]),
      .prod_o   (prod[k])
    );
  end

  sjva_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (state_q == S_XSUM),
    .prod_i (prod),
    .dot_o  (dot)
  );

  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < sjva_pkg::LANES; k++) begin
      if (item_q.component == 3'(k)) begin
        rd_sel = acc_rd[k];
      end
    end
  end

  assign done_o           = (state_q == S_RESP);
  assign res_o.status     = status_q;
  assign res_o.read_value = (!status_q && item_q.action == sjva_pkg::ACT_READ_ACC)
                            ? rd_sel : 32'sd0;

`ifndef SYNTHESIS
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("done not followed by idle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item did not raise busy");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status) |-> (res_o.read_value == 32'sd0))
    else $error("error result carries data");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(ctrl[0].acc_we || ctrl[0].x_we))
    else $error("memory write while idle");
`endif

endmodule
